// ===== hdl/lss_pkg.sv =====
// Shared types and constants for the lottery scheduler select block.
// Beat structs, status codes, controller state and command/status bundles.
// No dependencies.
package lss_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int TICKET_BITS_DEF = 16;

    localparam int ID_W     = 16;
    localparam int TIXIN_W  = 16;
    localparam int DRAW_W   = 20;
    localparam int SLOT_W   = 4;
    localparam int TOTAL_W  = 20;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED  = 3'd0,
        ST_WINNER = 3'd1,
        ST_FULL   = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_RANGE  = 3'd4
    } status_e_t;

    typedef struct packed {
        logic                 kind;
        logic [ID_W-1:0]      proc_id;
        logic [TIXIN_W-1:0]   ticket_count;
        logic [DRAW_W-1:0]    winning_ticket;
    } in_item_t;

    typedef struct packed {
        status_e_t            status;
        logic [ID_W-1:0]      winner_id;
        logic [SLOT_W-1:0]    winner_slot;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DECIDE = 2'd1,
        S_SCAN   = 2'd2,
        S_REPORT = 2'd3
    } state_e_t;

    typedef struct packed {
        logic      latch_item;
        logic      do_add;
        logic      scan_start;
        logic      scan_step;
        logic      set_res;
        status_e_t res_status;
        logic      load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic kind;
        logic full;
        logic empty;
        logic range_bad;
        logic hit;
        logic last;
    } dp_stat_t;

endpackage

// ===== hdl/lottery_scheduler_select.sv =====
// Top level of the lottery scheduler select block.
// Joins lss_ctrl and lss_datapath; depends on lss_pkg.
//
//  channel | direction | payload     | handshake
//  --------+-----------+-------------+----------------------
//  in      | to block  | in_item_t   | in_valid / in_stall
//  out     | from block| out_item_t  | out_valid / out_stall
//
// Add, table full, table empty and out-of-range draw pass through decide and report states.
// A winning draw also scans the table from slot 0 up to the winning slot, using the one
// running-sum adder and comparator stepping through the table's single read port.
// Reset clears entry count and ticket total; table contents need no clearing.
// A beat is taken only while idle; a stalled result holds the next one back.
module lottery_scheduler_select
    import lss_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    lss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lss_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .TICKET_BITS (TICKET_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

// ===== hdl/lss_datapath.sv =====
// Datapath: contender table memory, count and total registers, scan adder/comparator.
// Driven by lss_ctrl commands; depends on lss_pkg.
module lss_datapath
    import lss_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  ctl_cmd_t  cmd,
    output dp_stat_t  stat,
    output out_item_t out_data
);

    localparam int TIX_W = (TICKET_BITS < TIXIN_W) ? TICKET_BITS : TIXIN_W;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int RUN_W = TIX_W + CNT_W;
    localparam int CMP_W = (RUN_W > DRAW_W) ? RUN_W : DRAW_W;

    logic [ID_W-1:0]    id_mem  [MAX_ENTRIES];
    logic [TIX_W-1:0]   tix_mem [MAX_ENTRIES];

    in_item_t           item_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [ID_W-1:0]    first_id_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [RUN_W-1:0]   run_reg;
    logic [RUN_W-1:0]   run_next;
    logic [ID_W-1:0]    rd_id_reg;
    logic [TIX_W-1:0]   rd_tix_reg;
    out_item_t          res_reg;
    out_item_t          res_next;
    out_item_t          out_reg;

    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [TIX_W-1:0]   add_tix;
    logic [TOTAL_W:0]   total_sum;
    logic [RUN_W-1:0]   run_sum;
    logic [31:0]        cnt_wide;
    logic [31:0]        idx_wide;

    assign add_tix   = item_reg.ticket_count[TIX_W-1:0];
    assign wr_addr   = count_reg[IDX_W-1:0];
    assign rd_addr   = cmd.scan_start ? '0 : idx_reg + IDX_W'(1);
    assign total_sum = {1'b0, total_reg} + (TOTAL_W+1)'(add_tix);
    assign run_sum   = run_reg + RUN_W'(rd_tix_reg);
    assign cnt_wide  = 32'(count_reg);
    assign idx_wide  = 32'(idx_reg);

    assign stat.kind      = item_reg.kind;
    assign stat.full      = (count_reg == CNT_W'(MAX_ENTRIES));
    assign stat.empty     = (count_reg == '0);
    assign stat.range_bad = (item_reg.winning_ticket == '0) ||
                            (item_reg.winning_ticket > total_reg);
    assign stat.hit       = (CMP_W'(item_reg.winning_ticket) <= CMP_W'(run_sum));
    assign stat.last      = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign out_data = out_reg;

    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        if (cmd.do_add)
        begin
            count_next = count_reg + CNT_W'(1);
            total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        run_next = run_reg;
        if (cmd.scan_start)
        begin
            idx_next = '0;
            run_next = '0;
        end
        else if (cmd.scan_step)
        begin
            idx_next = idx_reg + IDX_W'(1);
            run_next = run_sum;
        end
    end

    always_comb
    begin
        res_next            = res_reg;
        if (cmd.set_res)
        begin
            res_next.status      = cmd.res_status;
            res_next.winner_id   = '0;
            res_next.winner_slot = '0;
            case (cmd.res_status)
                ST_ADDED:
                begin
                    res_next.winner_slot = cnt_wide[SLOT_W-1:0];
                end
                ST_WINNER:
                begin
                    res_next.winner_id   = rd_id_reg;
                    res_next.winner_slot = idx_wide[SLOT_W-1:0];
                end
                ST_RANGE:
                begin
                    res_next.winner_id = first_id_reg;
                end
                default:
                begin
                    res_next.winner_id = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.do_add && (count_reg == '0))
        begin
            first_id_reg <= item_reg.proc_id;
        end
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
        idx_reg <= idx_next;
        run_reg <= run_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_add)
        begin
            id_mem[wr_addr]  <= item_reg.proc_id;
            tix_mem[wr_addr] <= add_tix;
        end
        rd_id_reg  <= id_mem[rd_addr];
        rd_tix_reg <= tix_mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_add |=> total_reg >= $past(total_reg))
        else $error("ticket total decreased on add");

    a_scan_inside: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (CNT_W'(idx_reg) + CNT_W'(1)) < count_reg)
        else $error("scan stepped past last entry");
`endif

endmodule

// ===== hdl/lss_ctrl.sv =====
// Controller FSM: sequences accept, add/range decisions, table scan and output load.
// Drives lss_datapath commands from its status; depends on lss_pkg.
module lss_ctrl
    import lss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    state_e_t state_reg;
    state_e_t state_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if ((stat.kind == KIND_DRAW) && !stat.empty && !stat.range_bad)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end
            S_SCAN:
            begin
                if (stat.hit || stat.last)
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = ST_ADDED;
        case (state_reg)
            S_IDLE:
            begin
                cmd.latch_item = in_valid;
            end
            S_DECIDE:
            begin
                if (stat.kind == KIND_ADD)
                begin
                    cmd.set_res = 1'b1;
                    if (stat.full)
                    begin
                        cmd.res_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.do_add     = 1'b1;
                        cmd.res_status = ST_ADDED;
                    end
                end
                else if (stat.empty)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_EMPTY;
                end
                else if (stat.range_bad)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_RANGE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_WINNER;
                end
                else if (stat.last)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_RANGE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_REPORT:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd.latch_item = 1'b0;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DECIDE))
        else $error("accepted beat not followed by decode");

    a_hit_report: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && stat.hit) |=> (state_reg == S_REPORT))
        else $error("scan hit did not end the scan");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("result load lost");
`endif

endmodule
